@@ rtl/gsqr_pkg.sv @@
// ---------------------------------------------------------------------------
// gsqr_pkg
// Shared types and constants for the Gram-Schmidt QR block.
// ---------------------------------------------------------------------------
package gsqr_pkg;

   localparam int DATA_WIDTH_DEF = 32;
   localparam int FRAC_BITS_DEF  = 24;

   // internal words are 64-bit signed; the root and divider work on unsigned magnitudes
   localparam int IW = 64;

   // iterations of the square root / divider done in one register stage
   localparam int SQRT_STEPS = 2;
   localparam int DIV_STEPS  = 2;

   localparam logic [1:0] SIZE_2X2   = 2'd2;
   localparam logic [1:0] SIZE_RESET = 2'd3;

   typedef logic signed [IW-1:0] word_type;

   localparam logic [IW-1:0] MUL_LIMIT  = 64'h0000_007F_FFFF_FFFF;
   localparam logic [IW-1:0] PROD_LIMIT = 64'h1000_0000_0000_0000;
   localparam logic [IW-1:0] QUOT_LIMIT = 64'h4000_0000_0000_0000;
   localparam word_type      RES_LIMIT  = 64'sh0000_0002_0000_0000;

   // whole matrix context, [column][row]
   typedef struct packed {
      word_type [2:0][2:0] a;
      word_type [2:0][2:0] e;
      word_type [2:0][2:0] d;
      logic     [2:0]      degen;
   } ctx_type;

   typedef struct packed {
      ctx_type             ctx;
      word_type [2:0]      v;
   } work_type;

endpackage

@@ rtl/gsqr_sqrt.sv @@
// ---------------------------------------------------------------------------
// gsqr_sqrt
// Pipelined floor square root of a 64-bit value, two result bits per stage.
// ---------------------------------------------------------------------------
module gsqr_sqrt (
   input  logic                clock,
   input  logic                reset,
   input  logic                en,
   input  logic                in_valid,
   input  logic [63:0]         in_x,
   input  gsqr_pkg::work_type  in_work,
   output logic                out_valid,
   output logic [31:0]         out_root,
   output gsqr_pkg::work_type  out_work
);

   localparam int STEPS = gsqr_pkg::SQRT_STEPS;
   localparam int NS    = 32 / STEPS;

   logic               valid_ff [NS];
   logic [63:0]        rem_ff   [NS];
   logic [63:0]        rem_in   [NS];
   logic [63:0]        root_ff  [NS];
   logic [63:0]        root_in  [NS];
   gsqr_pkg::work_type work_ff  [NS];

   for (genvar g = 0; g < NS; g++) begin : g_stage
      logic               v_src;
      logic [63:0]        x_src;
      logic [63:0]        r_src;
      gsqr_pkg::work_type w_src;

      if (g == 0) begin : g_first
         assign v_src = in_valid;
         assign x_src = in_x;
         assign r_src = '0;
         assign w_src = in_work;
      end else begin : g_next
         assign v_src = valid_ff[g-1];
         assign x_src = rem_ff[g-1];
         assign r_src = root_ff[g-1];
         assign w_src = work_ff[g-1];
      end

      always_comb begin
         logic [63:0] x;
         logic [63:0] r;
         logic [63:0] b;
         logic [63:0] rb;
         x = x_src;
         r = r_src;
         for (int j = 0; j < STEPS; j++) begin
            b  = 64'd1 << (62 - 2 * (g * STEPS + j));
            rb = r + b;
            if (x >= rb) begin
               x = x - rb;
               r = (r >> 1) + b;
            end else begin
               r = r >> 1;
            end
         end
         rem_in[g]  = x;
         root_in[g] = r;
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[g] <= 1'b0;
         end else if (en) begin
            valid_ff[g] <= v_src;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[g]  <= rem_in[g];
            root_ff[g] <= root_in[g];
            work_ff[g] <= w_src;
         end
      end
   end

   assign out_valid = valid_ff[NS-1];
   assign out_root  = root_ff[NS-1][31:0];
   assign out_work  = work_ff[NS-1];

endmodule

@@ rtl/gsqr_div.sv @@
// ---------------------------------------------------------------------------
// gsqr_div
// Pipelined restoring divider, three 64-bit numerators over one 32-bit divisor.
// ---------------------------------------------------------------------------
module gsqr_div (
   input  logic                clock,
   input  logic                reset,
   input  logic                en,
   input  logic                in_valid,
   input  logic [31:0]         in_dvs,
   input  logic [2:0][63:0]    in_num,
   input  gsqr_pkg::work_type  in_work,
   output logic                out_valid,
   output logic [2:0][63:0]    out_quot,
   output gsqr_pkg::work_type  out_work
);

   localparam int STEPS = gsqr_pkg::DIV_STEPS;
   localparam int NS    = 64 / STEPS;

   logic               valid_ff [NS];
   logic [31:0]        dvs_ff   [NS];
   logic [2:0][63:0]   num_ff   [NS];
   logic [2:0][63:0]   num_in   [NS];
   logic [2:0][31:0]   rem_ff   [NS];
   logic [2:0][31:0]   rem_in   [NS];
   gsqr_pkg::work_type work_ff  [NS];

   for (genvar g = 0; g < NS; g++) begin : g_stage
      logic               v_src;
      logic [31:0]        d_src;
      logic [2:0][63:0]   n_src;
      logic [2:0][31:0]   r_src;
      gsqr_pkg::work_type w_src;

      if (g == 0) begin : g_first
         assign v_src = in_valid;
         assign d_src = in_dvs;
         assign n_src = in_num;
         assign r_src = '0;
         assign w_src = in_work;
      end else begin : g_next
         assign v_src = valid_ff[g-1];
         assign d_src = dvs_ff[g-1];
         assign n_src = num_ff[g-1];
         assign r_src = rem_ff[g-1];
         assign w_src = work_ff[g-1];
      end

      // numerator shifts out at the top, quotient bits shift in at the bottom
      always_comb begin
         logic [63:0] n;
         logic [31:0] r;
         logic [32:0] t;
         for (int k = 0; k < 3; k++) begin
            n = n_src[k];
            r = r_src[k];
            for (int j = 0; j < STEPS; j++) begin
               t = {r, n[63]};
               n = n << 1;
               if (t >= {1'b0, d_src}) begin
                  t    = t - {1'b0, d_src};
                  n[0] = 1'b1;
               end
               r = t[31:0];
            end
            num_in[g][k] = n;
            rem_in[g][k] = r;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[g] <= 1'b0;
         end else if (en) begin
            valid_ff[g] <= v_src;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            dvs_ff[g]  <= d_src;
            num_ff[g]  <= num_in[g];
            rem_ff[g]  <= rem_in[g];
            work_ff[g] <= w_src;
         end
      end
   end

   assign out_valid = valid_ff[NS-1];
   assign out_quot  = num_ff[NS-1];
   assign out_work  = work_ff[NS-1];

endmodule

@@ rtl/gsqr_col.sv @@
// ---------------------------------------------------------------------------
// gsqr_col
// One Gram-Schmidt column: projections, residual, norm, normalize, diagonal R.
// ---------------------------------------------------------------------------
module gsqr_col #(
   parameter int COL       = 0,
   parameter int FRAC_BITS = gsqr_pkg::FRAC_BITS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  logic              in_valid,
   input  gsqr_pkg::ctx_type in_ctx,
   output logic              out_valid,
   output gsqr_pkg::ctx_type out_ctx
);

   localparam logic [63:0] NMAX = 64'hFFFF_FFFF_FFFF_FFFF >> FRAC_BITS;

   // fixed-point product of saturated magnitudes, truncated toward zero and saturated
   function automatic gsqr_pkg::word_type mulq(input gsqr_pkg::word_type x,
                                               input gsqr_pkg::word_type y);
      logic [63:0] ux;
      logic [63:0] uy;
      logic [38:0] mx;
      logic [38:0] my;
      logic [38:0] ah;
      logic [38:0] al;
      logic [77:0] ph;
      logic [77:0] pl;
      logic [63:0] p;
      ux = x[63] ? (~x + 64'd1) : x;
      uy = y[63] ? (~y + 64'd1) : y;
      mx = (ux > gsqr_pkg::MUL_LIMIT) ? gsqr_pkg::MUL_LIMIT[38:0] : ux[38:0];
      my = (uy > gsqr_pkg::MUL_LIMIT) ? gsqr_pkg::MUL_LIMIT[38:0] : uy[38:0];
      ah = mx >> FRAC_BITS;
      al = mx & ((39'd1 << FRAC_BITS) - 39'd1);
      ph = ah * my;
      pl = al * my;
      p  = ph[63:0] + (pl[63:0] >> FRAC_BITS);
      if (p > gsqr_pkg::PROD_LIMIT) p = gsqr_pkg::PROD_LIMIT;
      return (x[63] ^ y[63]) ? $signed(~p + 64'd1) : $signed(p);
   endfunction

   function automatic gsqr_pkg::word_type res_clamp(input gsqr_pkg::word_type t);
      if (t > gsqr_pkg::RES_LIMIT) return gsqr_pkg::RES_LIMIT;
      if (t < -gsqr_pkg::RES_LIMIT) return -gsqr_pkg::RES_LIMIT;
      return t;
   endfunction

   // stage 1: products for the projections on earlier columns
   logic               v1_ff;
   gsqr_pkg::ctx_type  c1_ff;
   gsqr_pkg::word_type p1_ff [2][3];
   gsqr_pkg::word_type p1_in [2][3];

   always_comb begin
      for (int i = 0; i < 2; i++) begin
         for (int r = 0; r < 3; r++) begin
            p1_in[i][r] = (i < COL) ? mulq(in_ctx.a[COL][r], in_ctx.e[i][r]) : '0;
         end
      end
   end

   // stage 2: dot products
   logic              v2_ff;
   gsqr_pkg::ctx_type c2_ff;
   gsqr_pkg::ctx_type c2_in;

   always_comb begin
      c2_in = c1_ff;
      for (int i = 0; i < 2; i++) begin
         if (i < COL) begin
            c2_in.d[COL][i] = p1_ff[i][0] + p1_ff[i][1] + p1_ff[i][2];
         end
      end
   end

   // stages 3..6: subtract projections one earlier column at a time
   logic               v3_ff, v4_ff, v5_ff, v6_ff;
   gsqr_pkg::ctx_type  c3_ff, c4_ff, c5_ff, c6_ff;
   gsqr_pkg::word_type p3_ff [3];
   gsqr_pkg::word_type p3_in [3];
   gsqr_pkg::word_type r3_ff [3];
   gsqr_pkg::word_type r4_ff [3];
   gsqr_pkg::word_type r4_in [3];
   gsqr_pkg::word_type p5_ff [3];
   gsqr_pkg::word_type p5_in [3];
   gsqr_pkg::word_type r5_ff [3];
   gsqr_pkg::word_type r6_ff [3];
   gsqr_pkg::word_type r6_in [3];

   always_comb begin
      for (int r = 0; r < 3; r++) begin
         p3_in[r] = (COL > 0) ? mulq(c2_ff.d[COL][0], c2_ff.e[0][r]) : '0;
         r4_in[r] = (COL > 0) ? res_clamp(r3_ff[r] - p3_ff[r]) : r3_ff[r];
         p5_in[r] = (COL > 1) ? mulq(c4_ff.d[COL][1], c4_ff.e[1][r]) : '0;
         r6_in[r] = (COL > 1) ? res_clamp(r5_ff[r] - p5_ff[r]) : r5_ff[r];
      end
   end

   // stages 7..8: squared norm, saturated, scaled for the root
   logic               v7_ff, v8_ff;
   gsqr_pkg::ctx_type  c7_ff;
   gsqr_pkg::word_type s7_ff [3];
   gsqr_pkg::word_type s7_in [3];
   gsqr_pkg::word_type r7_ff [3];
   logic [63:0]        x8_ff, x8_in;
   gsqr_pkg::work_type w8_ff, w8_in;

   always_comb begin
      logic [63:0] s;
      for (int r = 0; r < 3; r++) begin
         s7_in[r] = mulq(r6_ff[r], r6_ff[r]);
      end
      s     = s7_ff[0] + s7_ff[1] + s7_ff[2];
      x8_in = ((s > NMAX) ? NMAX : s) << FRAC_BITS;
      w8_in.ctx = c7_ff;
      for (int r = 0; r < 3; r++) begin
         w8_in.v[r] = r7_ff[r];
      end
   end

   // control and payload registers for stages 1..8
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
         v6_ff <= 1'b0;
         v7_ff <= 1'b0;
         v8_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
         v6_ff <= v5_ff;
         v7_ff <= v6_ff;
         v8_ff <= v7_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         c1_ff <= in_ctx;
         p1_ff <= p1_in;
         c2_ff <= c2_in;
         c3_ff <= c2_ff;
         p3_ff <= p3_in;
         for (int r = 0; r < 3; r++) begin
            r3_ff[r] <= c2_ff.a[COL][r];
         end
         c4_ff <= c3_ff;
         r4_ff <= r4_in;
         c5_ff <= c4_ff;
         p5_ff <= p5_in;
         r5_ff <= r4_ff;
         c6_ff <= c5_ff;
         r6_ff <= r6_in;
         c7_ff <= c6_ff;
         s7_ff <= s7_in;
         r7_ff <= r6_ff;
         x8_ff <= x8_in;
         w8_ff <= w8_in;
      end
   end

   // norm
   logic               sq_valid;
   logic [31:0]        sq_root;
   gsqr_pkg::work_type sq_work;

   gsqr_sqrt u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (v8_ff),
      .in_x      (x8_ff),
      .in_work   (w8_ff),
      .out_valid (sq_valid),
      .out_root  (sq_root),
      .out_work  (sq_work)
   );

   // normalize each residual component
   gsqr_pkg::work_type dv_work_src;
   logic [2:0][63:0]   dv_num;
   logic               dv_valid;
   logic [2:0][63:0]   dv_quot;
   gsqr_pkg::work_type dv_work;

   always_comb begin
      logic [63:0] m;
      dv_work_src = sq_work;
      dv_work_src.ctx.degen[COL] = (sq_root == 32'd0);
      for (int r = 0; r < 3; r++) begin
         m = sq_work.v[r][63] ? (~sq_work.v[r] + 64'd1) : sq_work.v[r];
         dv_num[r] = m << FRAC_BITS;
      end
   end

   gsqr_div u_div (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (sq_valid),
      .in_dvs    (sq_root),
      .in_num    (dv_num),
      .in_work   (dv_work_src),
      .out_valid (dv_valid),
      .out_quot  (dv_quot),
      .out_work  (dv_work)
   );

   // stages 10..12: Q column, then its diagonal R entry
   logic               v10_ff, v11_ff, v12_ff;
   gsqr_pkg::ctx_type  c10_ff, c10_in;
   gsqr_pkg::ctx_type  c11_ff;
   gsqr_pkg::word_type p11_ff [3];
   gsqr_pkg::word_type p11_in [3];
   gsqr_pkg::ctx_type  c12_ff, c12_in;

   always_comb begin
      logic [63:0] q;
      c10_in = dv_work.ctx;
      for (int r = 0; r < 3; r++) begin
         q = (dv_quot[r] > gsqr_pkg::QUOT_LIMIT) ? gsqr_pkg::QUOT_LIMIT : dv_quot[r];
         if (dv_work.ctx.degen[COL]) begin
            c10_in.e[COL][r] = '0;
         end else begin
            c10_in.e[COL][r] = dv_work.v[r][63] ? $signed(~q + 64'd1) : $signed(q);
         end
      end
   end

   always_comb begin
      for (int r = 0; r < 3; r++) begin
         p11_in[r] = mulq(c10_ff.a[COL][r], c10_ff.e[COL][r]);
      end
      c12_in = c11_ff;
      c12_in.d[COL][COL] = p11_ff[0] + p11_ff[1] + p11_ff[2];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v10_ff <= 1'b0;
         v11_ff <= 1'b0;
         v12_ff <= 1'b0;
      end else if (en) begin
         v10_ff <= dv_valid;
         v11_ff <= v10_ff;
         v12_ff <= v11_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         c10_ff <= c10_in;
         c11_ff <= c10_ff;
         p11_ff <= p11_in;
         c12_ff <= c12_in;
      end
   end

   assign out_valid = v12_ff;
   assign out_ctx   = c12_ff;

endmodule

@@ rtl/gram_schmidt_qr_small_matrix.sv @@
// Pipeline: three column pipelines of 59 stages each, followed by the result register.
// Throughput is set by the result channel, which gives out one column per cycle while rsp_tready
// is high; the pipeline takes a matrix per cycle unless it is held for the result register.
// Reset: synchronous; clears all valid bits and the result register's valid and index, matrix_size goes to 3.
// ---------------------------------------------------------------------------
// gram_schmidt_qr_small_matrix
// Classical Gram-Schmidt QR of a 2x2 or 3x3 fixed-point matrix, one column per result.
// ---------------------------------------------------------------------------
module gram_schmidt_qr_small_matrix #(
   parameter int DATA_WIDTH = gsqr_pkg::DATA_WIDTH_DEF,
   parameter int FRAC_BITS  = gsqr_pkg::FRAC_BITS_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   // csr_wdata: matrix_size
   input  logic                                  csr_we,
   input  logic [1:0]                            csr_wdata,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   // req_tdata, low to high: col0_x, col0_y, col0_z, col1_x, col1_y, col1_z,
   // col2_x, col2_y, col2_z
   input  logic [((9*DATA_WIDTH+7)/8)*8-1:0]     req_tdata,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   // rsp_tdata, low to high: q_x, q_y, q_z, r_top, r_mid, r_bottom
   output logic [((6*DATA_WIDTH+7)/8)*8-1:0]     rsp_tdata,
   // rsp_tuser, low to high: column_index (2), degenerate
   output logic [2:0]                            rsp_tuser,
   output logic                                  rsp_tlast
);

   localparam int OUT_W = ((6*DATA_WIDTH+7)/8)*8;

   function automatic logic [DATA_WIDTH-1:0] sat_out(input gsqr_pkg::word_type v);
      logic [63:0]        hu;
      gsqr_pkg::word_type hi;
      gsqr_pkg::word_type lo;
      hu = 64'h7FFF_FFFF_FFFF_FFFF >> (64 - DATA_WIDTH);
      hi = $signed(hu);
      lo = ~hi;
      if (v > hi) return hi[DATA_WIDTH-1:0];
      if (v < lo) return lo[DATA_WIDTH-1:0];
      return v[DATA_WIDTH-1:0];
   endfunction

   logic [1:0] size_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff <= gsqr_pkg::SIZE_RESET;
      end else if (csr_we) begin
         size_ff <= csr_wdata;
      end
   end

   // unpack the matrix, z rows and column 2 forced to zero in 2x2 mode
   gsqr_pkg::ctx_type in_ctx;

   always_comb begin
      in_ctx = '0;
      for (int c = 0; c < 3; c++) begin
         for (int r = 0; r < 3; r++) begin
            if (!(size_ff == gsqr_pkg::SIZE_2X2 && (c == 2 || r == 2))) begin
               in_ctx.a[c][r] = 64'($signed(req_tdata[(c*3+r)*DATA_WIDTH +: DATA_WIDTH]));
            end
         end
      end
   end

   logic              en;
   logic              col0_valid, col1_valid, col2_valid;
   gsqr_pkg::ctx_type col0_ctx, col1_ctx, col2_ctx;

   assign req_tready = en;

   gsqr_col #(.COL(0), .FRAC_BITS(FRAC_BITS)) u_col0 (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (req_tvalid),
      .in_ctx    (in_ctx),
      .out_valid (col0_valid),
      .out_ctx   (col0_ctx)
   );

   gsqr_col #(.COL(1), .FRAC_BITS(FRAC_BITS)) u_col1 (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (col0_valid),
      .in_ctx    (col0_ctx),
      .out_valid (col1_valid),
      .out_ctx   (col1_ctx)
   );

   gsqr_col #(.COL(2), .FRAC_BITS(FRAC_BITS)) u_col2 (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (col1_valid),
      .in_ctx    (col1_ctx),
      .out_valid (col2_valid),
      .out_ctx   (col2_ctx)
   );

   // result register: holds one finished matrix and walks its columns
   logic              ser_valid_ff, ser_valid_in;
   logic [1:0]        idx_ff, idx_in;
   gsqr_pkg::ctx_type ser_ctx_ff;
   logic [1:0]        last_idx;
   logic              take;
   logic              done;
   logic              ser_free;
   logic              load;

   assign last_idx = (size_ff == gsqr_pkg::SIZE_2X2) ? 2'd1 : 2'd2;
   assign take     = ser_valid_ff && rsp_tready;
   assign done     = take && (idx_ff == last_idx);
   assign ser_free = !ser_valid_ff || done;
   assign load     = col2_valid && ser_free;
   // pipeline holds only when a finished matrix has nowhere to go
   assign en       = ser_free || !col2_valid;

   always_comb begin
      ser_valid_in = ser_valid_ff;
      idx_in       = idx_ff;
      if (load) begin
         ser_valid_in = 1'b1;
         idx_in       = 2'd0;
      end else if (done) begin
         ser_valid_in = 1'b0;
      end else if (take) begin
         idx_in = idx_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ser_valid_ff <= 1'b0;
         idx_ff       <= 2'd0;
      end else begin
         ser_valid_ff <= ser_valid_in;
         idx_ff       <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         ser_ctx_ff <= col2_ctx;
      end
   end

   logic [DATA_WIDTH-1:0] q_x, q_y, q_z, r_top, r_mid, r_bottom;

   always_comb begin
      q_x      = sat_out(ser_ctx_ff.e[idx_ff][0]);
      q_y      = sat_out(ser_ctx_ff.e[idx_ff][1]);
      q_z      = sat_out(ser_ctx_ff.e[idx_ff][2]);
      r_top    = sat_out(ser_ctx_ff.d[idx_ff][0]);
      r_mid    = (idx_ff != 2'd0) ? sat_out(ser_ctx_ff.d[idx_ff][1]) : '0;
      r_bottom = (idx_ff == 2'd2) ? sat_out(ser_ctx_ff.d[idx_ff][2]) : '0;
   end

   assign rsp_tvalid = ser_valid_ff;
   assign rsp_tdata  = OUT_W'({r_bottom, r_mid, r_top, q_z, q_y, q_x});
   assign rsp_tuser  = {ser_ctx_ff.degen[idx_ff], idx_ff};
   assign rsp_tlast  = (idx_ff == last_idx);

endmodule

@@ bench/gram_schmidt_qr_small_matrix_test.sv @@
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// gram_schmidt_qr_small_matrix_test
// Drives 2x2 and 3x3 matrices with random handshake gaps and checks every
// returned Q/R column against a fixed-point Gram-Schmidt predictor.
// ---------------------------------------------------------------------------
module gram_schmidt_qr_small_matrix_test;

   localparam int DW = 32;
   localparam int FB = 24;
   localparam int LATENCY = 178;
   localparam int WATCHDOG_LIMIT = 4000;

   typedef logic [9*DW-1:0] matrix_type;

   typedef struct packed {
      logic [1:0]    column_index;
      logic [DW-1:0] q_x, q_y, q_z, r_top, r_mid, r_bottom;
      logic          last;
      logic          degenerate;
   } column_type;

   logic clock = 0;
   logic reset = 1;
   logic csr_we = 0;
   logic [1:0] csr_wdata = '0;
   logic req_tvalid = 0;
   logic req_tready;
   logic [9*DW-1:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 0;
   logic [6*DW-1:0] rsp_tdata;
   logic [2:0] rsp_tuser;
   logic rsp_tlast;

   gram_schmidt_qr_small_matrix u_top (
      .clock(clock), .reset(reset),
      .csr_we(csr_we), .csr_wdata(csr_wdata),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser), .rsp_tlast(rsp_tlast)
   );

   always begin
      #4 clock = 1;
      #4 clock = 0;
   end

   matrix_type pending_matrices[$];
   column_type expected_columns[$];
   logic [1:0] size_setting = gsqr_pkg::SIZE_RESET;
   int errors = 0;
   int idle_cycles = 0;
   int send_gap = 0;
   int recv_gap = 0;

   task automatic queue_matrix(matrix_type m);
      pending_matrices = {pending_matrices, m};
   endtask

   // ---------------- fixed-point predictor ----------------
   function automatic logic [63:0] mag(logic signed [63:0] a);
      return a[63] ? -a : a;
   endfunction

   function automatic logic signed [63:0] signed_clamp(logic [63:0] m, logic neg,
                                                       logic [63:0] lim);
      if (m > lim) m = lim;
      return neg ? -$signed(m) : $signed(m);
   endfunction

   function automatic logic signed [63:0] fx_mul(logic signed [63:0] a,
                                                 logic signed [63:0] b);
      logic [63:0] ua, ub, p;
      ua = mag(a);
      ub = mag(b);
      if (ua > gsqr_pkg::MUL_LIMIT) ua = gsqr_pkg::MUL_LIMIT;
      if (ub > gsqr_pkg::MUL_LIMIT) ub = gsqr_pkg::MUL_LIMIT;
      p = (ua >> FB) * ub + (((ua & ((64'd1 << FB) - 1)) * ub) >> FB);
      return signed_clamp(p, a[63] != b[63], gsqr_pkg::PROD_LIMIT);
   endfunction

   function automatic logic [63:0] int_sqrt(logic [63:0] x);
      logic [63:0] r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > x) b = b >> 2;
      while (b != 0) begin
         if (x >= r + b) begin
            x = x - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   function automatic logic [DW-1:0] sat32(logic signed [63:0] v);
      if (v > 64'sh7FFF_FFFF) return 32'h7FFF_FFFF;
      if (v < -64'sh8000_0000) return 32'h8000_0000;
      return v[DW-1:0];
   endfunction

   task automatic predict_qr(matrix_type m);
      logic signed [63:0] a[3][3], e[3][3], d[3][3], v[3], t;
      logic [63:0] n2, nrm, nmax;
      int n;
      column_type res;
      n = (size_setting == gsqr_pkg::SIZE_2X2) ? 2 : 3;
      nmax = 64'hFFFF_FFFF_FFFF_FFFF >> FB;
      for (int c = 0; c < 3; c++)
         for (int r = 0; r < 3; r++) begin
            a[c][r] = $signed(m[(c*3+r)*DW +: DW]);
            if (n == 2 && (c == 2 || r == 2)) a[c][r] = 0;
            e[c][r] = 0;
            d[c][r] = 0;
         end
      for (int c = 0; c < n; c++) begin
         for (int r = 0; r < 3; r++) v[r] = a[c][r];
         for (int i = 0; i < c; i++) begin
            d[c][i] = fx_mul(a[c][0], e[i][0]) + fx_mul(a[c][1], e[i][1])
                      + fx_mul(a[c][2], e[i][2]);
            for (int r = 0; r < 3; r++) begin
               t = v[r] - fx_mul(d[c][i], e[i][r]);
               if (t > gsqr_pkg::RES_LIMIT) t = gsqr_pkg::RES_LIMIT;
               if (t < -gsqr_pkg::RES_LIMIT) t = -gsqr_pkg::RES_LIMIT;
               v[r] = t;
            end
         end
         n2 = 0;
         for (int r = 0; r < 3; r++) begin
            n2 = n2 + fx_mul(v[r], v[r]);
            if (n2 > nmax) n2 = nmax;
         end
         nrm = int_sqrt(n2 << FB);
         for (int r = 0; r < 3; r++)
            e[c][r] = (nrm == 0) ? 64'sd0
                      : signed_clamp((mag(v[r]) << FB) / nrm, v[r][63],
                                     gsqr_pkg::QUOT_LIMIT);
         d[c][c] = fx_mul(a[c][0], e[c][0]) + fx_mul(a[c][1], e[c][1])
                   + fx_mul(a[c][2], e[c][2]);
         res.column_index = c[1:0];
         res.q_x = sat32(e[c][0]);
         res.q_y = sat32(e[c][1]);
         res.q_z = sat32(e[c][2]);
         res.r_top = sat32(d[c][0]);
         res.r_mid = (c >= 1) ? sat32(d[c][1]) : '0;
         res.r_bottom = (c == 2) ? sat32(d[c][2]) : '0;
         res.last = (c == n - 1);
         res.degenerate = (nrm == 0);
         expected_columns = {expected_columns, res};
      end
   endtask

   // ---------------- driver ----------------
   always @(negedge clock) begin
      if (!reset) begin
         if (send_gap > 0) begin
            send_gap--;
            req_tvalid <= 0;
         end else if (pending_matrices.size() > 0) begin
            req_tvalid <= 1;
            req_tdata <= pending_matrices[0];
         end else begin
            req_tvalid <= 0;
         end
      end
   end

   // ---------------- monitor ----------------
   always @(negedge clock) begin
      if (!reset) begin
         if (recv_gap > 0) begin
            recv_gap--;
            rsp_tready <= 0;
         end else begin
            rsp_tready <= 1;
         end
      end
   end

   always @(posedge clock) begin
      column_type got, exp_col;
      if (!reset) begin
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle_cycles <= 0;
         else idle_cycles <= idle_cycles + 1;
         if (req_tvalid && req_tready) begin
            predict_qr(req_tdata);
            void'(pending_matrices.pop_front());
            send_gap = $urandom_range(0, 8);
            if ($urandom_range(0, 3) == 0) send_gap = 0;
         end
         if (rsp_tvalid && rsp_tready) begin
            got.column_index = rsp_tuser[1:0];
            got.degenerate = rsp_tuser[2];
            got.last = rsp_tlast;
            {got.r_bottom, got.r_mid, got.r_top, got.q_z, got.q_y, got.q_x} = rsp_tdata;
            if (expected_columns.size() == 0) begin
               errors++;
               if (errors <= 10) $display("unexpected column result %p", got);
            end else begin
               exp_col = expected_columns.pop_front();
               if (got !== exp_col) begin
                  errors++;
                  if (errors <= 10) $display("column mismatch: expected %p actual %p",
                                             exp_col, got);
               end
            end
            recv_gap = $urandom_range(0, 8);
            if ($urandom_range(0, 3) == 0) recv_gap = 0;
         end
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
         end
      end
   end

   // ---------------- stimulus ----------------
   function automatic logic [DW-1:0] rand_entry();
      case ($urandom_range(0, 5))
         0: return $urandom();
         1: return 32'h7FFF_FFFF;
         2: return 32'h8000_0000;
         3: return 32'h0;
         default: return $signed($urandom_range(0, 32'h0600_0000)) - 32'sh0300_0000;
      endcase
   endfunction

   function automatic matrix_type rand_matrix();
      matrix_type m;
      for (int k = 0; k < 9; k++) m[k*DW +: DW] = rand_entry();
      // occasionally make a column dependent on an earlier one
      if ($urandom_range(0, 5) == 0) m[2*3*DW +: 3*DW] = m[0 +: 3*DW];
      if ($urandom_range(0, 7) == 0) m[3*DW +: 3*DW] = m[0 +: 3*DW];
      return m;
   endfunction

   function automatic matrix_type fill(logic [DW-1:0] val);
      matrix_type m;
      for (int k = 0; k < 9; k++) m[k*DW +: DW] = val;
      return m;
   endfunction

   task automatic drain_and_set(logic [1:0] sz);
      while (pending_matrices.size() > 0 || expected_columns.size() > 0 || req_tvalid)
         @(posedge clock);
      repeat (LATENCY + 10) @(posedge clock);
      @(negedge clock);
      csr_we <= 1;
      csr_wdata <= sz;
      @(negedge clock);
      csr_we <= 0;
      size_setting = sz;
   endtask

   task automatic push_directed();
      matrix_type m;
      queue_matrix(fill(32'h0));
      queue_matrix(fill(32'h7FFF_FFFF));
      queue_matrix(fill(32'h8000_0000));
      queue_matrix(fill(32'hFFFF_FFFF));
      m = '0;
      m[0*DW +: DW] = 32'h0100_0000;
      m[4*DW +: DW] = 32'h0100_0000;
      m[8*DW +: DW] = 32'h0100_0000;
      queue_matrix(m);
      m[0 +: DW] = 32'h0;
      queue_matrix(m);
      queue_matrix(m ^ fill(32'hAAAA_5555));
   endtask

   initial begin
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 0;
      push_directed();
      for (int k = 0; k < 30; k++) queue_matrix(rand_matrix());
      drain_and_set(gsqr_pkg::SIZE_2X2);
      push_directed();
      for (int k = 0; k < 30; k++) queue_matrix(rand_matrix());
      drain_and_set(2'd0);
      for (int k = 0; k < 15; k++) queue_matrix(rand_matrix());
      drain_and_set(2'd1);
      for (int k = 0; k < 15; k++) queue_matrix(rand_matrix());
      drain_and_set(2'd3);
      for (int k = 0; k < 20; k++) queue_matrix(rand_matrix());
      while (pending_matrices.size() > 0 || expected_columns.size() > 0 || req_tvalid)
         @(posedge clock);
      repeat (LATENCY + 10) @(posedge clock);
      if (errors == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end
endmodule
